[design/tmps_pkg.sv]
// Shared types, widths and helpers for the triangle minimum path sum block.
// No dependencies; imported by tmps_front, tmps_back, the top level and tmps_checker.
`default_nettype none

package tmps_pkg;

	localparam int VAL_W = 16;  // one triangle entry
	localparam int SUM_W = 24;  // partial path sum
	localparam int OUT_W = 25;  // reported minimum

	// Classification of one accepted entry, handed from front to back.
	typedef struct packed {
		logic row0;      // apex row: the sum is the entry itself
		logic first_col; // only the upper parent exists
		logic last_col;  // only the upper-left parent exists
		logic last;      // final entry of the triangle
	} item_flags_t;

	localparam int FLAGS_W = $bits(item_flags_t);

	function automatic logic signed [SUM_W-1:0] smin(input logic signed [SUM_W-1:0] a,
		input logic signed [SUM_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

[design/tmps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tmps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read during write to the same address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/tmps_fifo.sv]
// Small register-based FIFO used for the front/back queue and the result queue.
// No dependencies.
`default_nettype none

module tmps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PLAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CFULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == CFULL);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PLAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PLAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/tmps_front.sv]
// Front end: accepts entries, tracks row/column position and classifies each beat.
// Depends on tmps_pkg.
`default_nettype none

module tmps_front #(
	parameter int MAX_ROWS = 256
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         push,
	input  wire logic signed [tmps_pkg::VAL_W-1:0]            value,
	input  wire logic                                         last,
	output logic                                              full,
	input  wire logic                                         q_full,
	output logic                                              q_push,
	output tmps_pkg::item_flags_t                             q_flags,
	output logic signed [tmps_pkg::VAL_W-1:0]                 q_value,
	output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] q_addr
);

	import tmps_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [AW-1:0] RLAST = AW'(MAX_ROWS - 1);

	logic [AW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic          accept;
	logic          at_row_end;

	assign full       = q_full;
	assign accept     = push && !q_full;
	assign at_row_end = (col_q == row_q);

	assign q_push            = accept;
	assign q_value           = value;
	assign q_addr            = col_q;
	assign q_flags.row0      = (row_q == '0);
	assign q_flags.first_col = (col_q == '0);
	assign q_flags.last_col  = at_row_end;
	assign q_flags.last      = last;

	// row index sticks at the last row; later rows reuse it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (at_row_end) begin
				col_q <= '0;
				row_q <= (row_q == RLAST) ? row_q : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/tmps_back.sv]
// Back end: row-sum RAM read, add-compare stage, row minimum and result push.
// Depends on tmps_pkg and tmps_ram.
`default_nettype none

module tmps_back #(
	parameter int MAX_ROWS = 256
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             q_empty,
	output logic                                                  q_pop,
	input  wire tmps_pkg::item_flags_t                            q_flags,
	input  wire logic signed [tmps_pkg::VAL_W-1:0]                q_value,
	input  wire logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0] q_addr,
	input  wire logic                                             res_full,
	output logic                                                  res_push,
	output logic signed [tmps_pkg::SUM_W-1:0]                     res_data
);

	import tmps_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic                     vld_s1;
	item_flags_t              flags_s1;
	logic signed [VAL_W-1:0]  value_s1;
	logic [AW-1:0]            addr_s1;
	logic                     byp_s1;
	logic signed [SUM_W-1:0]  byp_data_s1;

	logic signed [SUM_W-1:0]  left_q;
	logic signed [SUM_W-1:0]  min_q;

	logic signed [SUM_W-1:0]  ram_rdata;
	logic signed [SUM_W-1:0]  above;
	logic signed [SUM_W-1:0]  base;
	logic signed [SUM_W-1:0]  vext;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  new_min;
	logic                     fire;
	logic                     take;

	tmps_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (fire),
		.waddr (addr_s1),
		.wdata (sum),
		.re    (take),
		.raddr (q_addr),
		.rdata (ram_rdata)
	);

	// the beat behind may read the word this beat writes (row 1 col 0 after the apex)
	assign above = byp_s1 ? byp_data_s1 : ram_rdata;
	assign vext  = {{(SUM_W-VAL_W){value_s1[VAL_W-1]}}, value_s1};

	always_comb begin
		if (flags_s1.row0) begin
			base = '0;
		end else if (flags_s1.first_col) begin
			base = above;
		end else if (flags_s1.last_col) begin
			base = left_q;
		end else begin
			base = smin(left_q, above);
		end
	end

	assign sum     = base + vext;
	assign new_min = flags_s1.first_col ? sum : smin(min_q, sum);

	assign fire     = vld_s1 && (!flags_s1.last || !res_full);
	assign take     = !q_empty && (!vld_s1 || fire);
	assign q_pop    = take;
	assign res_push = fire && flags_s1.last;
	assign res_data = new_min;

	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1    <= q_flags;
			value_s1    <= q_value;
			addr_s1     <= q_addr;
			byp_data_s1 <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			left_q <= '0;
			min_q  <= '0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
				byp_s1 <= fire && (addr_s1 == q_addr);
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				if (flags_s1.last) begin
					left_q <= '0;
					min_q  <= '0;
				end else begin
					left_q <= above;
					min_q  <= new_min;
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/triangle_min_path_sum_top.sv]
// Top level of the triangle minimum path sum block.
// Depends on tmps_pkg, tmps_front, tmps_back and tmps_fifo.
//
// Entries of a number triangle stream in row-major order from the apex, one
// beat per clock sustained while the output queue has room; the beat flagged
// last yields one result, the minimum top-to-bottom path sum, sign-extended
// to 25 bits; the add-compare stage pushes it into the output queue. The
// rate is set by the single add-compare stage that reads one stored row sum
// from the row RAM and writes the new sum back in the same cycle. The front
// tracks the row/column position and feeds a two-beat queue; a two-result
// output queue lets the back keep working while results wait to be popped.
// The row RAM holds MAX_ROWS sums and needs no clearing after reset; rows
// beyond MAX_ROWS are treated as having MAX_ROWS entries.
`default_nettype none

module triangle_min_path_sum_top #(
	parameter int MAX_ROWS = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [tmps_pkg::VAL_W-1:0]   value,
	input  wire logic                                last,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [tmps_pkg::OUT_W-1:0]        min_total
);

	import tmps_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int QW = FLAGS_W + VAL_W + AW;

	logic                    q_push;
	item_flags_t             f_flags;
	logic signed [VAL_W-1:0] f_value;
	logic [AW-1:0]           f_addr;
	logic [QW-1:0]           q_wdata;
	logic [QW-1:0]           q_rdata;
	logic                    q_full;
	logic                    q_empty;
	logic                    q_pop;
	item_flags_t             b_flags;
	logic signed [VAL_W-1:0] b_value;
	logic [AW-1:0]           b_addr;

	logic                    res_push;
	logic [SUM_W-1:0]        res_wdata;
	logic [SUM_W-1:0]        res_rdata;
	logic                    res_full;

	tmps_front #(
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.value   (value),
		.last    (last),
		.full    (full),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_flags (f_flags),
		.q_value (f_value),
		.q_addr  (f_addr)
	);

	assign q_wdata = {f_flags, f_value, f_addr};

	tmps_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {b_flags, b_value, b_addr} = q_rdata;

	tmps_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_flags  (b_flags),
		.q_value  (b_value),
		.q_addr   (b_addr),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_wdata)
	);

	tmps_fifo #(
		.WIDTH(SUM_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_wdata),
		.rd     (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty)
	);

	assign min_total = {{(OUT_W-SUM_W){res_rdata[SUM_W-1]}}, res_rdata};

endmodule

`default_nettype wire

[design/tmps_checker.sv]
// Port-level checks for the triangle minimum path sum block, bound to the top.
// Depends on tmps_pkg and triangle_min_path_sum_top.
`default_nettype none

module tmps_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              push,
	input wire logic                              full,
	input wire logic                              last,
	input wire logic                              empty,
	input wire logic                              pop,
	input wire logic [tmps_pkg::OUT_W-1:0]        min_total
);

	import tmps_pkg::*;

	// last beats accepted whose result has not been popped yet
	logic [3:0] pend_q;
	logic       in_last;
	logic       out_beat;

	assign in_last  = push && !full && last;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_last && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_last) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != '0)
		else $error("result shown with no last beat outstanding");

	a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> pend_q != '0)
		else $error("input stalled with no result backing up");

	a_sign_extended: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> min_total[OUT_W-1] == min_total[OUT_W-2])
		else $error("min_total is not a sign-extended 24-bit sum");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(min_total))
		else $error("waiting result changed or vanished");

endmodule

bind triangle_min_path_sum_top tmps_checker u_tmps_checker (.*);

`default_nettype wire
